### src/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 stream block.
package mm3_pkg;

  // Mixing and finalization constants of MurmurHash3 x86 32-bit, and the reset seed.
  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] MIX_ADD  = 32'he6546b64;
  localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RST = 32'hdeadbeef;

  // Byte counts a word can carry.
  localparam logic [2:0] NBYTES_NONE  = 3'd0;
  localparam logic [2:0] NBYTES_ONE   = 3'd1;
  localparam logic [2:0] NBYTES_TWO   = 3'd2;
  localparam logic [2:0] NBYTES_THREE = 3'd3;
  localparam logic [2:0] NBYTES_FULL  = 3'd4;

  // Slots in the queue between the key mixer and the hash core.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One beat passed from the key mixer to the hash core.
  typedef struct packed {
    logic [31:0] key;     // mixed key, zero for an empty word
    logic [2:0]  nbytes;  // bytes absorbed by this beat, 0 to 4
    logic        last;    // final beat of the message
  } mm3_entry_t;

  // Keeps the low bytes of a word that carry message data.
  function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
    logic [31:0] m;
    case (nbytes)
      NBYTES_NONE:  m = 32'h0000_0000;
      NBYTES_ONE:   m = 32'h0000_00ff;
      NBYTES_TWO:   m = 32'h0000_ffff;
      NBYTES_THREE: m = 32'h00ff_ffff;
      default:      m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

### src/mm3_front.sv
// Input stage: accepts words, settles the byte count and mixes the key in two steps.
module mm3_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_data_word,
  input  logic [2:0]          in_byte_count,
  input  logic                in_last,
  output logic                push_valid,
  input  logic                push_ready,
  output mm3_pkg::mm3_entry_t push_entry
);
  import mm3_pkg::*;

  logic        a_v_r, a_v_nxt;
  logic [31:0] a_prod_r;
  logic [2:0]  a_nbytes_r;
  logic        a_last_r;
  logic        b_v_r, b_v_nxt;
  logic [31:0] b_key_r;
  logic [2:0]  b_nbytes_r;
  logic        b_last_r;
  logic        a_free, b_free;
  logic [2:0]  eff_nbytes;

  // A word that is not last, or a count above four, absorbs four bytes.
  always_comb begin
    if (!in_last || (in_byte_count > NBYTES_FULL)) begin
      eff_nbytes = NBYTES_FULL;
    end else begin
      eff_nbytes = in_byte_count;
    end
  end

  // Each stage moves on when the one after it is empty or draining.
  assign b_free   = !b_v_r || push_ready;
  assign a_free   = !a_v_r || b_free;
  assign in_ready = a_free;

  always_comb begin
    a_v_nxt = a_free ? in_valid : a_v_r;
    b_v_nxt = b_free ? a_v_r : b_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  // First multiply of the key mix; unused bytes are cleared first.
  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_prod_r   <= (in_data_word & byte_mask(eff_nbytes)) * MIX_C1;
      a_nbytes_r <= eff_nbytes;
      a_last_r   <= in_last;
    end
  end

  // Rotate and second multiply of the key mix.
  always_ff @(posedge clk) begin
    if (a_v_r && b_free) begin
      b_key_r    <= rotl15(a_prod_r) * MIX_C2;
      b_nbytes_r <= a_nbytes_r;
      b_last_r   <= a_last_r;
    end
  end

  assign push_valid        = b_v_r;
  assign push_entry.key    = b_key_r;
  assign push_entry.nbytes = b_nbytes_r;
  assign push_entry.last   = b_last_r;

endmodule

### src/mm3_fifo.sv
// Short queue that decouples the key mixer from the hash core.
module mm3_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  mm3_pkg::mm3_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mm3_pkg::mm3_entry_t pop_entry
);
  import mm3_pkg::*;

  localparam logic [QPTR_W:0] FULL_LEVEL = QUEUE_DEPTH[QPTR_W:0];

  mm3_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   level_r, level_nxt;
  logic              do_push, do_pop;

  assign push_ready = (level_r != FULL_LEVEL);
  assign pop_valid  = (level_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slot_r[rd_ptr_r];

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/mm3_back.sv
// Hash core: running hash recurrence, length count and the final avalanche pipeline.
module mm3_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         seed,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  mm3_pkg::mm3_entry_t pop_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_hash
);
  import mm3_pkg::*;

  logic        in_msg_r, in_msg_nxt;
  logic [31:0] run_r, run_nxt;
  logic [31:0] len_r, len_nxt;
  logic        f0_v_r, f0_v_nxt;
  logic        f1_v_r, f1_v_nxt;
  logic        f2_v_r, f2_v_nxt;
  logic        o_v_r, o_v_nxt;
  logic [31:0] f0_r, f1_r, f2_r, o_r;
  logic        f0_free, f1_free, f2_free, o_free;
  logic        do_pop, do_finish;
  logic [31:0] h_cur, h_x, h_rot, h_blk, len_sum;

  // Free chain of the avalanche pipeline, output register at its end.
  assign o_free  = !o_v_r || out_ready;
  assign f2_free = !f2_v_r || o_free;
  assign f1_free = !f1_v_r || f2_free;
  assign f0_free = !f0_v_r || f1_free;

  // A last beat waits for room in the avalanche pipeline.
  assign pop_ready = !pop_entry.last || f0_free;
  assign do_pop    = pop_valid && pop_ready;
  assign do_finish = do_pop && pop_entry.last;

  // Block or tail mix of one beat; an empty beat carries a zero key.
  always_comb begin
    h_cur   = in_msg_r ? run_r : seed;
    h_x     = h_cur ^ pop_entry.key;
    h_rot   = rotl13(h_x);
    h_blk   = (pop_entry.nbytes == NBYTES_FULL) ?
              ((h_rot << 2) + h_rot + MIX_ADD) : h_x;
    len_sum = len_r + {29'd0, pop_entry.nbytes};
  end

  // Message state update.
  always_comb begin
    in_msg_nxt = in_msg_r;
    run_nxt    = run_r;
    len_nxt    = len_r;
    if (do_pop) begin
      if (pop_entry.last) begin
        in_msg_nxt = 1'b0;
        len_nxt    = '0;
      end else begin
        in_msg_nxt = 1'b1;
        run_nxt    = h_blk;
        len_nxt    = len_sum;
      end
    end
  end

  // Stage valids advance whenever the next stage has room.
  always_comb begin
    f0_v_nxt = f0_free ? do_finish : f0_v_r;
    f1_v_nxt = f1_free ? f0_v_r : f1_v_r;
    f2_v_nxt = f2_free ? f1_v_r : f2_v_r;
    o_v_nxt  = o_free ? f2_v_r : o_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
      f0_v_r   <= 1'b0;
      f1_v_r   <= 1'b0;
      f2_v_r   <= 1'b0;
      o_v_r    <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
      f0_v_r   <= f0_v_nxt;
      f1_v_r   <= f1_v_nxt;
      f2_v_r   <= f2_v_nxt;
      o_v_r    <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
  end

  // Length fold, two multiply steps and the closing shift of the avalanche.
  always_ff @(posedge clk) begin
    if (do_finish) begin
      f0_r <= h_blk ^ len_sum;
    end
    if (f0_v_r && f1_free) begin
      f1_r <= (f0_r ^ (f0_r >> 16)) * FIN_M1;
    end
    if (f1_v_r && f2_free) begin
      f2_r <= (f1_r ^ (f1_r >> 13)) * FIN_M2;
    end
    if (f2_v_r && o_free) begin
      o_r <= f2_r ^ (f2_r >> 16);
    end
  end

  assign out_valid = o_v_r;
  assign out_hash  = o_r;

endmodule

### src/murmur3_32_hash_stream.sv
// MurmurHash3 x86 32-bit: top level with the seed register and the three parts wired up.
//
// The block hashes a message of little-endian 32-bit words and takes one word
// per clock cycle, sustained while the hash output is not backed up, with no
// gap between messages. The rate is set by the hash recurrence in the core,
// which folds one word into the running hash each cycle; the key mix ahead of
// it is a two-stage multiply pipeline feeding a four-beat queue. A hash is
// valid once its last word has passed the two key mix stages, a slot in the
// queue, the core, then two avalanche stages and the output register; it
// waits longer when the queue holds earlier beats or the output is backed up.
// The output register holds the hash until it is taken. A seed write applies
// from the next message whose first word reaches the core.
module murmur3_32_hash_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash
);
  import mm3_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  mm3_entry_t  push_entry, pop_entry;

  // Seed register.
  always_comb begin
    seed_nxt = cfg_we ? cfg_wdata : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mm3_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  mm3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mm3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hash  (out_hash)
  );

endmodule
